[hdl/source_port_acl_filter_top_defines.svh]
// assertion macros for the source port acl filter checker
// no dependencies; pulled in by the checker with `include
`ifndef SOURCE_PORT_ACL_FILTER_TOP_DEFINES_SVH
`define SOURCE_PORT_ACL_FILTER_TOP_DEFINES_SVH

// clocked assertion, switched off while reset is high
`define SAPF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds across reset
`define SAPF_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/sapf_pkg.sv]
// shared types, codes and sizes of the source port acl filter
// no dependencies
`timescale 1ns / 1ps

package sapf_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int KEY_W             = 48;

   typedef logic [KEY_W-1:0] key_type;

   localparam logic       CMD_ADD    = 1'b0;
   localparam logic       CMD_CHECK  = 1'b1;
   localparam logic       MODE_BLACK = 1'b0;
   localparam logic       MODE_WHITE = 1'b1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   function automatic key_type make_key(input logic [31:0] addr, input logic [15:0] port);
      make_key = {addr, port};
   endfunction

endpackage

[hdl/sapf_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sapf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sapf_ctrl.sv]
// sequencer of the acl filter: appends entries, scans the table, holds the result beat
// depends on sapf_pkg; drives the table ram ports
`timescale 1ns / 1ps

module sapf_ctrl
   import sapf_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   localparam int CW = $clog2(TABLE_ENTRIES + 1),
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          filter_mode,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_command,
   input  logic [31:0]   req_src_addr,
   input  logic [15:0]   req_src_port,
   input  logic [7:0]    req_ip_protocol,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_accept,
   output logic          rsp_table_full,
   output logic          ram_wr_en,
   output logic [AW-1:0] ram_wr_addr,
   output key_type       ram_wr_data,
   output logic          ram_rd_en,
   output logic [AW-1:0] ram_rd_addr,
   input  key_type       ram_rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic          hit_ff, hit_in;
   key_type       key_ff, key_in;
   logic          res_accept_ff, res_accept_in;
   logic          res_full_ff, res_full_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_accept_ff, rsp_accept_in;
   logic          rsp_full_ff, rsp_full_in;

   logic          table_full;
   logic          new_hit;
   logic          is_tcp_udp;

   assign table_full = (count_ff == CW'(TABLE_ENTRIES));
   assign is_tcp_udp = (req_ip_protocol == PROTO_TCP) || (req_ip_protocol == PROTO_UDP);
   // pend marks that the ram output holds the entry read in the previous cycle
   assign new_hit    = hit_ff || (pend_ff && (ram_rd_data == key_ff));

   // new beats are taken only in idle, so the append write always lands
   // before any scan read of the same entry
   assign req_ready   = (state_ff == ST_IDLE);
   assign ram_wr_addr = count_ff[AW-1:0];
   assign ram_wr_data = make_key(req_src_addr, req_src_port);
   assign ram_rd_addr = idx_ff[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      hit_in        = hit_ff;
      key_in        = key_ff;
      res_accept_in = res_accept_ff;
      res_full_in   = res_full_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_accept_in = rsp_accept_ff;
      rsp_full_in   = rsp_full_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in   = make_key(req_src_addr, req_src_port);
               state_in = ST_DONE;
               if (req_command == CMD_ADD) begin
                  res_accept_in = 1'b0;
                  res_full_in   = table_full;
                  if (!table_full) begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CW'(1);
                  end
               end else if (is_tcp_udp) begin
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  hit_in   = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  res_accept_in = 1'b1;
                  res_full_in   = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            hit_in = new_hit;
            // stop on the first match or once the last stored entry is compared
            if (new_hit || (idx_ff == count_ff)) begin
               res_accept_in = (filter_mode == MODE_WHITE) ? new_hit : !new_hit;
               res_full_in   = 1'b0;
               pend_in       = 1'b0;
               state_in      = ST_DONE;
            end else begin
               ram_rd_en = 1'b1;
               idx_in    = idx_ff + CW'(1);
               pend_in   = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_accept_in = res_accept_ff;
               rsp_full_in   = res_full_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      key_ff        <= key_in;
      res_accept_ff <= res_accept_in;
      res_full_ff   <= res_full_in;
      rsp_accept_ff <= rsp_accept_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accept     = rsp_accept_ff;
   assign rsp_table_full = rsp_full_ff;

endmodule

[hdl/source_port_acl_filter_top.sv]
// top level of the source port acl filter: mode register, sequencer and entry table
// depends on sapf_pkg, sapf_ctrl and sapf_ram
`timescale 1ns / 1ps

// Source address/port access-list filter.
// req_* beat: command 0 appends {src_addr, src_port} to the table, command 1 checks a
// packet. Each beat gives exactly one rsp_* beat: accept (1 pass, 0 drop; 0 for adds)
// and table_full (an add that found the table full and was dropped).
// csr_write_en/csr_write_data set filter_mode (0 blacklist, 1 whitelist); write it
// only while no beat is in flight.
// An add or a non-TCP/UDP check skips the table scan; a TCP/UDP check first
// compares the stored entries in order, up to the fill count, and stops early on a
// match. The next req beat is taken only after the result is loaded, so the block
// works on one item at a time. The scan is set by the single table read port with
// its registered read data, one entry per cycle.
// The result register frees the request side: a new beat is accepted while a result
// still waits for rsp_ready; a stalled receiver only holds up the following result.
// Reset empties the table (fill count to zero, contents left as they are), clears
// the result valid flag and sets blacklist mode; no clearing pass is needed.
module source_port_acl_filter_top
   import sapf_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_src_addr,
   input  logic [15:0] req_src_port,
   input  logic [7:0]  req_ip_protocol,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accept,
   output logic        rsp_table_full
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic          mode_ff;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   key_type       ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   key_type       ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BLACK;
      end else if (csr_write_en) begin
         mode_ff <= csr_write_data;
      end
   end

   sapf_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .filter_mode    (mode_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_src_addr   (req_src_addr),
      .req_src_port   (req_src_port),
      .req_ip_protocol(req_ip_protocol),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_accept     (rsp_accept),
      .rsp_table_full (rsp_table_full),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   sapf_ram #(
      .WIDTH(KEY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

endmodule

[hdl/sapf_checker.sv]
// port-level checks of the source port acl filter, bound to the top level
// depends on source_port_acl_filter_top_defines.svh
`timescale 1ns / 1ps
`include "source_port_acl_filter_top_defines.svh"

module sapf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accept,
   input logic        rsp_table_full
);

   // a stalled result beat keeps its payload
   `SAPF_ASSERT(a_rsp_hold,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accept) && $stable(rsp_table_full),
      "rsp beat changed while stalled")

   // a dropped add never reports a pass
   `SAPF_ASSERT(a_flags_excl, rsp_valid |-> !(rsp_accept && rsp_table_full),
      "accept and table_full both set")

   `SAPF_ASSERT_RST(a_reset_rsp, reset |=> !rsp_valid, "rsp_valid after reset")

   // one item at a time: taking a beat closes the request side
   `SAPF_ASSERT(a_one_item, req_valid && req_ready |=> !req_ready,
      "req_ready held after a beat")

   // no result appears on the same edge that takes a request
   `SAPF_ASSERT(a_no_zero_lat, req_valid && req_ready |=> !$rose(rsp_valid),
      "result in zero cycles")

endmodule

bind source_port_acl_filter_top sapf_checker u_sapf_checker (.*);

[sim/source_port_acl_filter_top_tb.sv]
// self-checking testbench for the source port acl filter: directed table, then random beats
// depends on sapf_pkg and source_port_acl_filter_top; results vs typed rows or a local model
`timescale 1ns / 1ps

module source_port_acl_filter_top_tb;
   import sapf_pkg::*;

   localparam int TABLE_DEPTH    = TABLE_ENTRIES_DEF;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RAND_PER_PHASE = 160;
   localparam int DRAIN_CYCLES   = 300;

   typedef struct packed {
      logic        command;
      logic [31:0] src_addr;
      logic [15:0] src_port;
      logic [7:0]  ip_protocol;
   } acl_req_type;

   typedef struct packed {
      logic accept;
      logic table_full;
   } acl_result_type;

   typedef enum logic [1:0] {KEEP_MODE, SET_BLACK, SET_WHITE} mode_act_type;
   typedef enum logic {FROM_PREDICTOR, TYPED_IN} exp_src_type;

   typedef struct packed {
      mode_act_type mode_act;
      logic         command;
      logic [31:0]  src_addr;
      logic [15:0]  src_port;
      logic [7:0]   ip_protocol;
      exp_src_type  exp_src;
      logic         exp_accept;
      logic         exp_full;
   } dir_row_type;

   localparam int DIR_ROWS = 21;

   // empty table first, then a few entries, both modes, protocols on either side of tcp/udp
   dir_row_type dir_rows [DIR_ROWS] = '{
      '{KEEP_MODE, CMD_CHECK, 32'h0000_0000, 16'h0000, PROTO_TCP, TYPED_IN, 1'b1, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'hFFFF_FFFF, 16'hFFFF, PROTO_UDP, TYPED_IN, 1'b1, 1'b0},
      '{SET_WHITE, CMD_CHECK, 32'h0000_0000, 16'h0000, PROTO_TCP, TYPED_IN, 1'b0, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'h0000_0000, 16'h0000, 8'd0, TYPED_IN, 1'b1, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 8'd255, TYPED_IN, 1'b1, 1'b0},
      '{KEEP_MODE, CMD_ADD, 32'h0000_0000, 16'h0000, PROTO_TCP, TYPED_IN, 1'b0, 1'b0},
      '{KEEP_MODE, CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 8'd255, TYPED_IN, 1'b0, 1'b0},
      '{KEEP_MODE, CMD_ADD, 32'hC0A8_0001, 16'h0050, 8'd0, TYPED_IN, 1'b0, 1'b0},
      '{KEEP_MODE, CMD_ADD, 32'hC0A8_0001, 16'h0050, PROTO_UDP, TYPED_IN, 1'b0, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'h0000_0000, 16'h0000, PROTO_TCP, FROM_PREDICTOR, 1'b0, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'hFFFF_FFFF, 16'hFFFF, PROTO_UDP, FROM_PREDICTOR, 1'b0, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'hC0A8_0001, 16'h0051, PROTO_TCP, FROM_PREDICTOR, 1'b0, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'hC0A8_0002, 16'h0050, PROTO_UDP, FROM_PREDICTOR, 1'b0, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'hC0A8_0001, 16'h0050, 8'd7, TYPED_IN, 1'b1, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'h0000_0000, 16'h0000, 8'd16, TYPED_IN, 1'b1, 1'b0},
      '{SET_BLACK, CMD_CHECK, 32'hC0A8_0001, 16'h0050, PROTO_TCP, FROM_PREDICTOR, 1'b0, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'h1234_5678, 16'hABCD, PROTO_UDP, FROM_PREDICTOR, 1'b0, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 8'd5, TYPED_IN, 1'b1, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 8'd18, TYPED_IN, 1'b1, 1'b0},
      '{KEEP_MODE, CMD_ADD, 32'h8000_0001, 16'h8001, PROTO_UDP, TYPED_IN, 1'b0, 1'b0},
      '{KEEP_MODE, CMD_CHECK, 32'h8000_0001, 16'h8001, PROTO_TCP, FROM_PREDICTOR, 1'b0, 1'b0}
   };

   int   src_idle_pct [3] = '{14, 60, 0};
   int   sink_idle_pct [3] = '{60, 14, 0};
   logic phase_mode [3]    = '{MODE_WHITE, MODE_BLACK, MODE_WHITE};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = 1'b0;
   logic [31:0] req_src_addr = '0;
   logic [15:0] req_src_port = '0;
   logic [7:0]  req_ip_protocol = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_accept;
   logic        rsp_table_full;

   // local copy of the filter state
   logic [47:0]     acl_keys [$];
   logic            acl_mode = MODE_BLACK;
   acl_result_type  expected_results [$];

   int src_idle  = 14;
   int sink_idle = 60;
   int mismatches = 0;
   int cycle_count = 0;
   int adds_taken = 0;
   int adds_refused = 0;
   int checks_passed = 0;
   int checks_dropped = 0;

   source_port_acl_filter_top DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_src_addr    (req_src_addr),
      .req_src_port    (req_src_port),
      .req_ip_protocol (req_ip_protocol),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_accept      (rsp_accept),
      .rsp_table_full  (rsp_table_full)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic acl_result_type filter_predict(input acl_req_type r);
      acl_result_type res;
      logic           hit;
      logic [47:0]    key;
      res = '0;
      hit = 1'b0;
      key = {r.src_addr, r.src_port};
      if (r.command == CMD_ADD) begin
         if (acl_keys.size() >= TABLE_DEPTH) begin
            res.table_full = 1'b1;
         end else begin
            acl_keys.push_back(key);
         end
      end else if (r.ip_protocol == PROTO_TCP || r.ip_protocol == PROTO_UDP) begin
         foreach (acl_keys[k]) begin
            if (acl_keys[k] == key) hit = 1'b1;
         end
         res.accept = (acl_mode == MODE_WHITE) ? hit : !hit;
      end else begin
         res.accept = 1'b1;
      end
      return res;
   endfunction

   // mostly adds until the table fills, checks lean on stored keys and one-bit near misses
   function automatic acl_req_type random_beat();
      acl_req_type r;
      logic [47:0] key;
      int unsigned roll;
      int unsigned add_pct;
      r.src_addr    = $urandom();
      r.src_port    = $urandom_range(0, 65535);
      r.ip_protocol = $urandom_range(0, 255);
      key = {r.src_addr, r.src_port};
      add_pct = (acl_keys.size() >= TABLE_DEPTH) ? 20 : 70;
      if ($urandom_range(0, 99) < add_pct) begin
         r.command = CMD_ADD;
         if (acl_keys.size() != 0 && $urandom_range(0, 99) < 15)
            key = acl_keys[$urandom_range(0, acl_keys.size() - 1)];
      end else begin
         r.command = CMD_CHECK;
         roll = $urandom_range(0, 99);
         if (roll < 45) r.ip_protocol = PROTO_TCP;
         else if (roll < 90) r.ip_protocol = PROTO_UDP;
         roll = $urandom_range(0, 99);
         if (acl_keys.size() != 0 && roll < 70) begin
            key = acl_keys[$urandom_range(0, acl_keys.size() - 1)];
            if (roll >= 45) key = key ^ (48'h1 << $urandom_range(0, 47));
         end
      end
      {r.src_addr, r.src_port} = key;
      return r;
   endfunction

   // called just after a rising edge; returns at the edge that takes the beat
   task automatic drive_beat(input acl_req_type r, input exp_src_type src,
                             input acl_result_type typed);
      acl_result_type pred;
      while ($urandom_range(0, 99) < src_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= r.command;
      req_src_addr    <= r.src_addr;
      req_src_port    <= r.src_port;
      req_ip_protocol <= r.ip_protocol;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = filter_predict(r);
      expected_results.push_back((src == TYPED_IN) ? typed : pred);
      if (r.command == CMD_ADD) begin
         if (pred.table_full) adds_refused++;
         else adds_taken++;
      end else if (pred.accept) begin
         checks_passed++;
      end else begin
         checks_dropped++;
      end
   endtask

   task automatic set_mode(input logic m);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_en <= 1'b0;
      acl_mode = m;
   endtask

   always @(posedge clock) begin
      acl_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result beat with nothing expected: accept %0b table_full %0b",
                   rsp_accept, rsp_table_full);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_accept !== want.accept) begin
               $error("accept: expected %0b, got %0b", want.accept, rsp_accept);
               mismatches++;
            end
            if (rsp_table_full !== want.table_full) begin
               $error("table_full: expected %0b, got %0b", want.table_full, rsp_table_full);
               mismatches++;
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= sink_idle);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("run stopped after %0d cycles, %0d results outstanding",
                cycle_count, expected_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      acl_req_type    r;
      acl_result_type typed;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].mode_act == SET_WHITE) set_mode(MODE_WHITE);
         else if (dir_rows[i].mode_act == SET_BLACK) set_mode(MODE_BLACK);
         r.command     = dir_rows[i].command;
         r.src_addr    = dir_rows[i].src_addr;
         r.src_port    = dir_rows[i].src_port;
         r.ip_protocol = dir_rows[i].ip_protocol;
         typed.accept     = dir_rows[i].exp_accept;
         typed.table_full = dir_rows[i].exp_full;
         drive_beat(r, dir_rows[i].exp_src, typed);
      end

      for (int p = 0; p < 3; p++) begin
         set_mode(phase_mode[p]);
         src_idle  = src_idle_pct[p];
         sink_idle = sink_idle_pct[p];
         for (int i = 0; i < RAND_PER_PHASE; i++) drive_beat(random_beat(), FROM_PREDICTOR, '0);
      end

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d stored adds, %0d adds refused on a full table (%0d entries held)",
               adds_taken, adds_refused, acl_keys.size());
      $display("covered %0d checks passed and %0d dropped over both filter modes",
               checks_passed, checks_dropped);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/sapf_pkg.sv
hdl/sapf_ram.sv
hdl/sapf_ctrl.sv
hdl/source_port_acl_filter_top.sv
hdl/sapf_checker.sv
sim/source_port_acl_filter_top_tb.sv
